// ----- hw/rtl/mbpf_pkg.sv -----
// Shared types and constants for the masked byte pattern finder.
// Holds the transaction structs, status codes and register indexes.
// No dependencies.
package mbpf_pkg;

    localparam int          PATTERN_MAX_DEF = 8;
    localparam int          PAT_BYTES       = 8;
    localparam int          BYTE_W          = 8;
    localparam int          ADDR_W          = 32;
    localparam int          LEN_W           = 4;
    localparam int          CFG_IDX_W       = 2;
    localparam int          CFG_DATA_W      = 64;
    localparam logic [ADDR_W-1:0] MIN_VALID_BASE = 32'h0000_1000;

    typedef enum logic [1:0] {
        ST_FOUND       = 2'd0,
        ST_NOT_FOUND   = 2'd1,
        ST_BAD_PATTERN = 2'd2,
        ST_BAD_RANGE   = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES  = 2'd0,
        CFG_PATTERN_MASK   = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2,
        CFG_BASE_ADDRESS   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] match_address;
    } t_out;

    // Per-cell compare setup handed from the lane map to each cell.
    typedef struct packed {
        logic              care;
        logic [BYTE_W-1:0] want;
    } t_lane;

endpackage

// ----- hw/rtl/mbpf_cell.sv -----
// One window cell of the masked byte pattern finder: holds one byte.
// Compares the byte it is taking in against its lane's pattern byte.
// Depends on mbpf_pkg.
module mbpf_cell
    import mbpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  logic              i_clear,
    input  logic [BYTE_W-1:0] i_byte,
    input  t_lane             i_lane,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_hit
);

    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_clear) begin
            n_byte = '0;
        end else if (i_shift) begin
            n_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else begin
            r_byte <= n_byte;
        end
    end

    // Match is judged on the byte entering this cell, i.e. the window after the shift.
    assign o_hit  = !i_lane.care || (i_byte == i_lane.want);
    assign o_byte = r_byte;

endmodule

// ----- hw/rtl/masked_byte_pattern_finder_core.sv -----
// Masked byte pattern finder: scans a byte stream for a wildcard byte signature.
// Top level; uses mbpf_pkg and a chain of mbpf_cell window cells.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in) carries one memory byte per
//   transaction, the first at the configured base address; last_byte ends a scan.
//   Output channel (o_out_valid / i_out_ready / o_out) carries at most one result
//   per scan: found with the match start address, or on the last byte not found,
//   invalid pattern (length 0 or above PATTERN_MAX) or invalid range (base below
//   0x1000). Bytes after a match give no result; the last byte then ends the scan.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data while idle.
// Timing:
//   One byte per cycle sustained. Each byte shifts the cell chain by one and all
//   cells compare in parallel in the same cycle; the result is loaded into the
//   output register at the edge that takes the byte. The output register refills
//   in the cycle it drains, so a stalled receiver only holds back input while a
//   result waits: o_in_ready = !o_out_valid || i_out_ready.
// Reset:
//   Clears the window, byte count, match flag, output valid flag and all
//   configuration registers. The window and count also clear after each last byte.
module masked_byte_pattern_finder_core
    import mbpf_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [PAT_BYTES*BYTE_W-1:0] r_pat_bytes;
    logic [PAT_BYTES-1:0]        r_pat_mask;
    logic [LEN_W-1:0]            r_pat_len;
    logic [ADDR_W-1:0]           r_base;

    // Scan state
    logic [ADDR_W-1:0] r_seen;
    logic [ADDR_W-1:0] n_seen;
    logic              r_reported;
    logic              n_reported;

    logic              r_out_valid;
    logic              n_out_valid;
    t_out              r_out;
    t_out              n_out;

    logic              in_fire;
    logic              scan;
    logic              pat_ok;
    logic              range_ok;
    logic              found;
    logic              report_end;
    logic [ADDR_W-1:0] seen_inc;

    t_lane             lane     [PATTERN_MAX];
    logic [BYTE_W-1:0] cell_in  [PATTERN_MAX];
    logic [BYTE_W-1:0] cell_out [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_bytes <= '0;
            r_pat_mask  <= '0;
            r_pat_len   <= '0;
            r_base      <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PATTERN_BYTES:  r_pat_bytes <= i_cfg_data;
                CFG_PATTERN_MASK:   r_pat_mask  <= i_cfg_data[PAT_BYTES-1:0];
                CFG_PATTERN_LENGTH: r_pat_len   <= i_cfg_data[LEN_W-1:0];
                CFG_BASE_ADDRESS:   r_base      <= i_cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    assign pat_ok   = (r_pat_len != '0) && (r_pat_len <= LEN_W'(PATTERN_MAX));
    assign range_ok = (r_base >= MIN_VALID_BASE);

    // Cell k holds the k-th newest byte; it checks pattern byte (len - 1 - k).
    always_comb begin
        logic [LEN_W-1:0] idx;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            idx          = r_pat_len - LEN_W'(1) - LEN_W'(k);
            lane[k].care = (LEN_W'(k) < r_pat_len) && r_pat_mask[idx[2:0]];
            lane[k].want = r_pat_bytes[BYTE_W*idx[2:0] +: BYTE_W];
        end
    end

    genvar g;
    generate
        for (g = 0; g < PATTERN_MAX; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign cell_in[g] = i_in.data_byte;
            end else begin : g_link
                assign cell_in[g] = cell_out[g-1];
            end
            mbpf_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (scan),
                .i_clear (in_fire && i_in.last_byte),
                .i_byte  (cell_in[g]),
                .i_lane  (lane[g]),
                .o_byte  (cell_out[g]),
                .o_hit   (hit[g])
            );
        end
    endgenerate

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;
    assign scan       = in_fire && !r_reported;

    // Saturate the byte count at all ones.
    assign seen_inc = (r_seen == '1) ? r_seen : r_seen + ADDR_W'(1);

    assign found = scan && pat_ok && range_ok
                   && (seen_inc >= {{(ADDR_W-LEN_W){1'b0}}, r_pat_len}) && (&hit);
    assign report_end = scan && !found && i_in.last_byte;

    always_comb begin
        n_seen     = r_seen;
        n_reported = r_reported;
        if (scan) begin
            n_seen = seen_inc;
        end
        if (found) begin
            n_reported = 1'b1;
        end
        if (in_fire && i_in.last_byte) begin
            n_seen     = '0;
            n_reported = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (found) begin
            n_out_valid         = 1'b1;
            n_out.status        = ST_FOUND;
            n_out.match_address = r_base + seen_inc - {{(ADDR_W-LEN_W){1'b0}}, r_pat_len};
        end else if (report_end) begin
            n_out_valid         = 1'b1;
            n_out.match_address = '0;
            if (!pat_ok) begin
                n_out.status = ST_BAD_PATTERN;
            end else if (!range_ok) begin
                n_out.status = ST_BAD_RANGE;
            end else begin
                n_out.status = ST_NOT_FOUND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= '0;
            r_reported  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_seen      <= n_seen;
            r_reported  <= n_reported;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_last_clears_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.last_byte) |=> (!r_reported && r_seen == '0))
        else $error("scan state not cleared after last byte");

    a_no_addr_unless_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ST_FOUND) |-> (o_out.match_address == '0))
        else $error("match address set on a non-found result");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

    a_count_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (scan && !i_in.last_byte) |=> (r_seen != '0))
        else $error("byte count did not advance");

    a_found_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (found && !i_in.last_byte) |=> r_reported)
        else $error("match flag not set after a found result");
`endif

endmodule
